/* rtl/serial_rx_chunk_buffer_timeout_macros.svh */
// Assertion macros shared by the serial receive chunk buffer modules.
// Depends on nothing; include by bare file name.
`ifndef SERIAL_RX_CHUNK_BUFFER_TIMEOUT_MACROS_SVH
`define SERIAL_RX_CHUNK_BUFFER_TIMEOUT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SRXCB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srxcb same-cycle check failed");

// next-cycle implication, disabled in reset
`define SRXCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srxcb next-cycle check failed");

`endif

/* rtl/srxcb_pkg.sv */
// Package for the serial receive chunk buffer: sizes, codes and the
// timer control/status structs. Used by every module of the block but the RAM.
package srxcb_pkg;

   localparam int CHUNK_SIZE       = 32;
   localparam int OVERFLOW_RESERVE = 32;
   localparam int STORE_DEPTH      = CHUNK_SIZE + OVERFLOW_RESERVE;

   localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int FILL_W = $clog2(STORE_DEPTH + 1);
   localparam int CNT_W  = $clog2(CHUNK_SIZE + 1);
   localparam int SUM_W  = FILL_W + 1;

   localparam int BYTE_W     = 8;
   localparam int OP_W       = 2;
   localparam int MODE_W     = 2;
   localparam int TIMEOUT_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd250;

   // operation codes
   localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // data mode codes
   localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PASS   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BUFFER = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DATA_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_IE  = 2'd2;

   typedef struct packed {
      logic              tick;
      logic              arm;
      logic [FILL_W-1:0] fill_after;
   } tmr_ctrl_type;

   typedef struct packed {
      logic armed;
      logic expire;
   } tmr_sts_type;

endpackage

/* rtl/srxcb_ram.sv */
// Generic simple dual-port RAM with registered read and read enable.
// Stands alone; no package needed.
module srxcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/srxcb_ptr_add.sv */
// Shared pointer adder: base plus offset, wrapped into the store depth.
// Depends on srxcb_pkg.
module srxcb_ptr_add
   import srxcb_pkg::*;
(
   input  logic [PTR_W-1:0]  base,
   input  logic [FILL_W-1:0] offset,
   output logic [PTR_W-1:0]  sum
);

   logic [SUM_W-1:0] raw;
   logic [SUM_W-1:0] wrapped;

   // the sum stays below twice the depth, so one subtract wraps
   always_comb begin
      raw     = SUM_W'(base) + SUM_W'(offset);
      wrapped = (raw >= SUM_W'(STORE_DEPTH)) ? raw - SUM_W'(STORE_DEPTH) : raw;
      sum     = wrapped[PTR_W-1:0];
   end

endmodule

/* rtl/srxcb_timer.sv */
// One-shot idle timer counted in millisecond ticks.
// Depends on srxcb_pkg and the assertion macro header.
`include "serial_rx_chunk_buffer_timeout_macros.svh"

module srxcb_timer
   import srxcb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tmr_ctrl_type         ctrl,
   input  logic [TIMEOUT_W-1:0] timeout,
   output tmr_sts_type          sts
);

   logic [TIMEOUT_W-1:0] count_ff;
   logic [TIMEOUT_W-1:0] count_in;
   logic                 armed_ff;
   logic                 armed_in;
   logic                 fire;

   assign fire = ctrl.tick && armed_ff && (count_ff <= TIMEOUT_W'(1));

   always_comb begin
      count_in = count_ff;
      armed_in = armed_ff;
      if (ctrl.arm) begin
         // a full chunk or a zero timeout expires on the next tick
         if ((timeout == '0) || (ctrl.fill_after >= FILL_W'(CHUNK_SIZE))) begin
            count_in = TIMEOUT_W'(1);
         end else begin
            count_in = timeout;
         end
         armed_in = 1'b1;
      end else if (fire) begin
         count_in = '0;
         armed_in = 1'b0;
      end else if (ctrl.tick && armed_ff) begin
         count_in = count_ff - TIMEOUT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         armed_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         armed_ff <= armed_in;
      end
   end

   assign sts.armed  = armed_ff;
   assign sts.expire = fire;

   `SRXCB_ASSERT_IMPLY(a_armed_nonzero, clock, reset, armed_ff, count_ff != '0)
   `SRXCB_ASSERT_NEXT(a_fire_disarms, clock, reset, fire && !ctrl.arm, !armed_ff)
   `SRXCB_ASSERT_NEXT(a_arm_sets, clock, reset, ctrl.arm, armed_ff && (count_ff != '0))

endmodule

/* rtl/serial_rx_chunk_buffer_timeout.sv */
// Serial receive buffer with idle-timeout chunk delivery. Each request item
// (byte, tick or clear) is accepted whenever the block is idle. A byte in
// pass mode is registered and held in SEND until the output takes it. A
// tick that expires the timer starts a delivery of up to CHUNK_SIZE stored
// bytes, each read in READ via the store's registered read port and held
// in SEND through output stalls; requests are stalled for the whole delivery.
// The store needs no clearing pass after reset. Config writes are always ready.
`include "serial_rx_chunk_buffer_timeout_macros.svh"

module serial_rx_chunk_buffer_timeout
   import srxcb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_data,
   output logic                  rsp_from_chunk,
   output logic                  rsp_last,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic                 chunk_ie_ff, chunk_ie_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   logic                 chunk_ff, chunk_in;
   logic [BYTE_W-1:0]    pass_data_ff, pass_data_in;

   logic                 req_accept;
   logic                 rsp_accept;
   logic                 csr_write;
   logic [FILL_W-1:0]    ptr_offset;
   logic [PTR_W-1:0]     ptr_sum;
   logic                 ram_we;
   logic                 ram_re;
   logic [BYTE_W-1:0]    ram_rdata;
   tmr_ctrl_type         tmr_ctrl;
   tmr_sts_type          tmr_sts;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_SEND);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   srxcb_ptr_add u_ptr_add (
      .base   (head_ff),
      .offset (ptr_offset),
      .sum    (ptr_sum)
   );

   srxcb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ptr_sum),
      .wr_data (req_rx_byte),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   srxcb_timer u_timer (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (tmr_ctrl),
      .timeout (timeout_ff),
      .sts     (tmr_sts)
   );

   always_comb begin
      state_in            = state_ff;
      mode_in             = mode_ff;
      timeout_in          = timeout_ff;
      chunk_ie_in         = chunk_ie_ff;
      fill_in             = fill_ff;
      head_in             = head_ff;
      left_in             = left_ff;
      chunk_in            = chunk_ff;
      pass_data_in        = pass_data_ff;
      ptr_offset          = fill_ff;
      ram_we              = 1'b0;
      ram_re              = 1'b0;
      tmr_ctrl.tick       = 1'b0;
      tmr_ctrl.arm        = 1'b0;
      tmr_ctrl.fill_after = fill_ff;

      if (csr_write) begin
         unique case (csr_index)
            REG_DATA_MODE: begin
               mode_in = csr_wdata[MODE_W-1:0];
               if (mode_in == MODE_BUFFER) begin
                  fill_in = '0;
                  head_in = '0;
               end else if (mode_in == MODE_PASS) begin
                  chunk_ie_in = 1'b0;
               end
            end
            REG_TIMEOUT: begin
               timeout_in = csr_wdata[TIMEOUT_W-1:0];
            end
            REG_CHUNK_IE: begin
               chunk_ie_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_operation)
                  OP_BYTE: begin
                     if (mode_ff == MODE_PASS) begin
                        pass_data_in = req_rx_byte;
                        chunk_in     = 1'b0;
                        state_in     = ST_SEND;
                     end else if ((mode_ff == MODE_BUFFER) &&
                                  (fill_ff < FILL_W'(STORE_DEPTH))) begin
                        // append at head + fill; drop when full
                        ram_we  = 1'b1;
                        fill_in = fill_ff + FILL_W'(1);
                        if (chunk_ie_ff && (fill_ff < FILL_W'(CHUNK_SIZE))) begin
                           tmr_ctrl.arm        = 1'b1;
                           tmr_ctrl.fill_after = fill_ff + FILL_W'(1);
                        end
                     end
                  end
                  OP_TICK: begin
                     tmr_ctrl.tick = 1'b1;
                     if (tmr_sts.expire) begin
                        if (fill_ff == '0) begin
                           head_in = '0;
                        end else begin
                           left_in  = (fill_ff >= FILL_W'(CHUNK_SIZE)) ?
                                      CNT_W'(CHUNK_SIZE) : fill_ff[CNT_W-1:0];
                           chunk_in = 1'b1;
                           state_in = ST_READ;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     fill_in = '0;
                     head_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            ptr_offset = FILL_W'(1);
            if (rsp_accept) begin
               if (chunk_ff) begin
                  // advance past the byte just delivered
                  head_in = ptr_sum;
                  fill_in = fill_ff - FILL_W'(1);
                  left_in = left_ff - CNT_W'(1);
                  if (left_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                     if (fill_ff == FILL_W'(1)) begin
                        head_in = '0;
                     end else begin
                        tmr_ctrl.arm        = 1'b1;
                        tmr_ctrl.fill_after = fill_ff - FILL_W'(1);
                     end
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= MODE_IGNORE;
         timeout_ff  <= TIMEOUT_RESET;
         chunk_ie_ff <= 1'b0;
         fill_ff     <= '0;
         head_ff     <= '0;
         chunk_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         timeout_ff  <= timeout_in;
         chunk_ie_ff <= chunk_ie_in;
         fill_ff     <= fill_in;
         head_ff     <= head_in;
         chunk_ff    <= chunk_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      pass_data_ff <= pass_data_in;
   end

   assign rsp_data       = chunk_ff ? ram_rdata : pass_data_ff;
   assign rsp_from_chunk = chunk_ff;
   assign rsp_last       = chunk_ff ? (left_ff == CNT_W'(1)) : 1'b1;

   `SRXCB_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(STORE_DEPTH))
   `SRXCB_ASSERT_IMPLY(a_chunk_left, clock, reset, rsp_valid && chunk_ff, (left_ff != '0) && (fill_ff >= FILL_W'(left_ff)))
   `SRXCB_ASSERT_IMPLY(a_deliver_disarmed, clock, reset, (state_ff != ST_IDLE) && chunk_ff, !tmr_sts.armed)
   `SRXCB_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_accept && rsp_last, state_ff == ST_IDLE)

endmodule
